@@ design/mksm_pkg.sv @@
package mksm_pkg;

  localparam int unsigned STATES   = 64;
  localparam int unsigned KEYWORDS = 16;
  localparam int unsigned ALPHABET = 256;

  localparam int unsigned SW         = $clog2(STATES);
  localparam int unsigned AW         = $clog2(ALPHABET);
  localparam int unsigned GA         = SW + AW;
  localparam int unsigned GOTO_DEPTH = STATES * ALPHABET;
  localparam int unsigned CW         = SW + 1;
  localparam int unsigned KW         = $clog2(KEYWORDS);
  localparam int unsigned KCW        = $clog2(KEYWORDS + 1);
  localparam int unsigned MASKW      = 16;
  localparam int unsigned NCW        = 5;
  localparam int unsigned POSW       = 16;
  localparam int unsigned SYMW       = 8;
  localparam int unsigned IUSERW     = 3;
  localparam int unsigned ODATAW     = 40;
  localparam int unsigned OUSERW     = 2;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_BUILD  = 2'd2,
    FUNC_MATCH  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_KWORDS = 2'd2,
    STAT_NBUILT = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic ins_read;
    logic ins_update;
    logic bld_init;
    logic ch_read;
    logic ch_check;
    logic fg_read;
    logic fg_check;
    logic fl_load;
    logic own_read;
    logic own_write;
    logic np_read;
    logic pw_load;
    logic pf_load;
    logic m_read;
    logic m_check;
    logic m_fail;
    logic m_mask;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_e in_func;
    logic  built;
    logic  sweep_last;
    logic  goto_hit;
    logic  a_last;
    logic  root_phase;
    logic  f_root;
    logic  s_root;
    logic  q_more;
    logic  out_free;
  } sts_t;

endpackage

@@ design/mksm_ram.sv @@
module mksm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mksm_ctrl.sv @@
module mksm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mksm_pkg::sts_t sts_i,
  output mksm_pkg::cmd_t cmd_o
);

  typedef enum logic [20:0] {
    S_RSWEEP   = 21'd1 << 0,
    S_IDLE     = 21'd1 << 1,
    S_CSWEEP   = 21'd1 << 2,
    S_INS_RD   = 21'd1 << 3,
    S_INS_UPD  = 21'd1 << 4,
    S_BINIT    = 21'd1 << 5,
    S_CH_RD    = 21'd1 << 6,
    S_CH_CHK   = 21'd1 << 7,
    S_FG_RD    = 21'd1 << 8,
    S_FG_CHK   = 21'd1 << 9,
    S_FL_WAIT  = 21'd1 << 10,
    S_OWN_RD   = 21'd1 << 11,
    S_OWN_WAIT = 21'd1 << 12,
    S_NP       = 21'd1 << 13,
    S_PW       = 21'd1 << 14,
    S_PF       = 21'd1 << 15,
    S_M_RD     = 21'd1 << 16,
    S_M_CHK    = 21'd1 << 17,
    S_M_FL     = 21'd1 << 18,
    S_M_OM     = 21'd1 << 19,
    S_RESP     = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_RSWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.in_func)
            mksm_pkg::FUNC_CLEAR:  state_d = S_CSWEEP;
            mksm_pkg::FUNC_INSERT: state_d = S_INS_RD;
            mksm_pkg::FUNC_BUILD:  state_d = S_BINIT;
            mksm_pkg::FUNC_MATCH:  state_d = sts_i.built ? S_M_RD : S_RESP;
            default:               state_d = S_RESP;
          endcase
        end
      end
      S_CSWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_RESP;
      end
      S_INS_RD: begin
        cmd_o.ins_read = 1'b1;
        state_d = S_INS_UPD;
      end
      S_INS_UPD: begin
        cmd_o.ins_update = 1'b1;
        state_d = S_RESP;
      end
      S_BINIT: begin
        cmd_o.bld_init = 1'b1;
        state_d = S_CH_RD;
      end
      S_CH_RD: begin
        cmd_o.ch_read = 1'b1;
        state_d = S_CH_CHK;
      end
      S_CH_CHK: begin
        cmd_o.ch_check = 1'b1;
        if (sts_i.goto_hit) begin
          state_d = sts_i.root_phase ? S_OWN_RD : S_FG_RD;
        end else begin
          state_d = sts_i.a_last ? S_NP : S_CH_RD;
        end
      end
      S_FG_RD: begin
        cmd_o.fg_read = 1'b1;
        state_d = S_FG_CHK;
      end
      S_FG_CHK: begin
        cmd_o.fg_check = 1'b1;
        state_d = (!sts_i.goto_hit && !sts_i.f_root) ? S_FL_WAIT : S_OWN_RD;
      end
      S_FL_WAIT: begin
        cmd_o.fl_load = 1'b1;
        state_d = S_FG_RD;
      end
      S_OWN_RD: begin
        cmd_o.own_read = 1'b1;
        state_d = S_OWN_WAIT;
      end
      S_OWN_WAIT: begin
        cmd_o.own_write = 1'b1;
        state_d = sts_i.a_last ? S_NP : S_CH_RD;
      end
      S_NP: begin
        cmd_o.np_read = 1'b1;
        state_d = sts_i.q_more ? S_PW : S_RESP;
      end
      S_PW: begin
        cmd_o.pw_load = 1'b1;
        state_d = S_PF;
      end
      S_PF: begin
        cmd_o.pf_load = 1'b1;
        state_d = S_CH_RD;
      end
      S_M_RD: begin
        cmd_o.m_read = 1'b1;
        state_d = S_M_CHK;
      end
      S_M_CHK: begin
        cmd_o.m_check = 1'b1;
        state_d = (!sts_i.goto_hit && !sts_i.s_root) ? S_M_FL : S_M_OM;
      end
      S_M_FL: begin
        cmd_o.m_fail = 1'b1;
        state_d = S_M_RD;
      end
      S_M_OM: begin
        cmd_o.m_mask = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RSWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/mksm_dp.sv @@
module mksm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mksm_pkg::cmd_t                  cmd_i,
  output mksm_pkg::sts_t                  sts_o,
  input  logic [mksm_pkg::SYMW-1:0]       s_tdata_i,
  input  logic                            s_tlast_i,
  input  logic [mksm_pkg::IUSERW-1:0]     s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [mksm_pkg::ODATAW-1:0]     m_tdata_o,
  output logic [mksm_pkg::OUSERW-1:0]     m_tuser_o
);

  localparam int unsigned SW    = mksm_pkg::SW;
  localparam int unsigned AW    = mksm_pkg::AW;
  localparam int unsigned GA    = mksm_pkg::GA;
  localparam int unsigned CW    = mksm_pkg::CW;
  localparam int unsigned KW    = mksm_pkg::KW;
  localparam int unsigned KCW   = mksm_pkg::KCW;
  localparam int unsigned MASKW = mksm_pkg::MASKW;
  localparam int unsigned NCW   = mksm_pkg::NCW;
  localparam int unsigned POSW  = mksm_pkg::POSW;

  logic                 goto_we;
  logic [GA-1:0]        goto_waddr, goto_raddr;
  logic [SW-1:0]        goto_wdata, goto_rdata;
  logic                 fail_we;
  logic [SW-1:0]        fail_waddr, fail_wdata, fail_raddr, fail_rdata;
  logic                 om_we;
  logic [SW-1:0]        om_waddr, om_raddr;
  logic [MASKW-1:0]     om_wdata, om_rdata;
  logic                 own_we;
  logic [SW-1:0]        own_waddr;
  logic [KW-1:0]        own_wdata, own_rdata;
  logic                 q_we;
  logic [SW-1:0]        q_rdata;

  logic [GA-1:0]        sweep_q, sweep_d;
  logic [SW-1:0]        ins_q, ins_d, ms_q, ms_d, s_q, s_d;
  logic [SW-1:0]        p_q, p_d, t_q, t_d, f_q, f_d, fp_q, fp_d, g_q, g_d;
  logic [SW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        sc_q, sc_d;
  logic [KCW-1:0]       kc_q, kc_d;
  logic [POSW-1:0]      pos_q, pos_d;
  logic                 built_q, built_d, drop_q, drop_d, root_q, root_d;
  logic [mksm_pkg::STATES-1:0] vld_q, vld_d;
  logic [AW-1:0]        a_q, a_d;
  logic                 last_q, last_d, start_q, start_d;
  logic [MASKW-1:0]     rmask_q, rmask_d;
  logic [POSW-1:0]      rpos_q, rpos_d;
  mksm_pkg::status_e    rstat_q, rstat_d;
  logic                 mvalid_q, mvalid_d;
  logic [mksm_pkg::ODATAW-1:0] mdata_q, mdata_d;
  logic [mksm_pkg::OUSERW-1:0] muser_q, muser_d;

  logic                 hit;
  logic [SW-1:0]        tsel;
  logic [MASKW-1:0]     own_bits;
  logic [NCW-1:0]       ones;
  mksm_pkg::func_e      in_func;

  assign hit     = (goto_rdata != '0);
  assign in_func = mksm_pkg::func_e'(s_tuser_i[1:0]);

  assign own_bits = vld_q[t_q] ? (MASKW'(1) << own_rdata) : '0;

  always_comb begin
    ones = '0;
    for (int i = 0; i < MASKW; i++) begin
      ones = ones + NCW'(rmask_q[i]);
    end
  end

  mksm_ram #(.Width(SW), .Depth(mksm_pkg::GOTO_DEPTH)) u_goto (
    .clk_i, .we_i(goto_we), .waddr_i(goto_waddr), .wdata_i(goto_wdata),
    .raddr_i(goto_raddr), .rdata_o(goto_rdata)
  );

  mksm_ram #(.Width(SW), .Depth(mksm_pkg::STATES)) u_fail (
    .clk_i, .we_i(fail_we), .waddr_i(fail_waddr), .wdata_i(fail_wdata),
    .raddr_i(fail_raddr), .rdata_o(fail_rdata)
  );

  mksm_ram #(.Width(MASKW), .Depth(mksm_pkg::STATES)) u_outmask (
    .clk_i, .we_i(om_we), .waddr_i(om_waddr), .wdata_i(om_wdata),
    .raddr_i(om_raddr), .rdata_o(om_rdata)
  );

  mksm_ram #(.Width(KW), .Depth(mksm_pkg::STATES)) u_own (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(own_wdata),
    .raddr_i(t_q), .rdata_o(own_rdata)
  );

  mksm_ram #(.Width(SW), .Depth(mksm_pkg::STATES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(tail_q), .wdata_i(goto_rdata),
    .raddr_i(head_q), .rdata_o(q_rdata)
  );

  always_comb begin
    sweep_d = sweep_q;  ins_d = ins_q;  ms_d = ms_q;  s_d = s_q;
    p_d = p_q;  t_d = t_q;  f_d = f_q;  fp_d = fp_q;  g_d = g_q;
    head_d = head_q;  tail_d = tail_q;  sc_d = sc_q;  kc_d = kc_q;
    pos_d = pos_q;  built_d = built_q;  drop_d = drop_q;  root_d = root_q;
    vld_d = vld_q;  a_d = a_q;  last_d = last_q;  start_d = start_q;
    rmask_d = rmask_q;  rpos_d = rpos_q;  rstat_d = rstat_q;
    mvalid_d = mvalid_q;  mdata_d = mdata_q;  muser_d = muser_q;
    tsel = goto_rdata;

    goto_we = 1'b0;  goto_waddr = sweep_q;  goto_wdata = '0;
    goto_raddr = {s_q, a_q};
    fail_we = 1'b0;  fail_waddr = t_q;  fail_wdata = g_q;  fail_raddr = s_q;
    om_we = 1'b0;  om_waddr = t_q;  om_wdata = own_bits | om_rdata;  om_raddr = g_q;
    own_we = 1'b0;  own_waddr = goto_rdata;  own_wdata = kc_q[KW-1:0];
    q_we = 1'b0;

    if (m_tready_i) mvalid_d = 1'b0;

    if (cmd_i.sweep_step) begin
      goto_we = 1'b1;
      sweep_d = sweep_q + GA'(1);
    end

    if (cmd_i.accept) begin
      a_d     = s_tdata_i[AW-1:0];
      last_d  = s_tlast_i;
      start_d = s_tuser_i[2];
      rmask_d = '0;
      rpos_d  = '0;
      rstat_d = mksm_pkg::STAT_OK;
      unique case (in_func)
        mksm_pkg::FUNC_CLEAR: begin
          sweep_d = '0;  sc_d = CW'(1);  kc_d = '0;  ins_d = '0;  ms_d = '0;
          pos_d = '0;  built_d = 1'b0;  drop_d = 1'b0;  vld_d = '0;
        end
        mksm_pkg::FUNC_MATCH: begin
          if (!built_q) begin
            rstat_d = mksm_pkg::STAT_NBUILT;
          end else if (s_tuser_i[2]) begin
            s_d   = '0;
            pos_d = '0;
          end else begin
            s_d = ms_q;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.ins_read) goto_raddr = {ins_q, a_q};

    if (cmd_i.ins_update) begin
      if (drop_q) begin
        rstat_d = mksm_pkg::STAT_FULL;
      end else if (!hit && sc_q >= CW'(mksm_pkg::STATES)) begin
        drop_d  = 1'b1;
        rstat_d = mksm_pkg::STAT_FULL;
      end else begin
        if (!hit) begin
          goto_we    = 1'b1;
          goto_waddr = {ins_q, a_q};
          goto_wdata = sc_q[SW-1:0];
          sc_d       = sc_q + CW'(1);
          tsel       = sc_q[SW-1:0];
        end
        ins_d = tsel;
        if (last_q) begin
          if (kc_q >= KCW'(mksm_pkg::KEYWORDS)) begin
            rstat_d = mksm_pkg::STAT_KWORDS;
          end else begin
            own_we      = 1'b1;
            own_waddr   = tsel;
            vld_d[tsel] = 1'b1;
            kc_d        = kc_q + KCW'(1);
          end
        end
      end
      built_d = 1'b0;
      if (last_q) begin
        drop_d = 1'b0;
        ins_d  = '0;
      end
    end

    if (cmd_i.bld_init) begin
      fail_we = 1'b1;  fail_waddr = '0;  fail_wdata = '0;
      om_we   = 1'b1;  om_waddr   = '0;  om_wdata   = '0;
      head_d = '0;  tail_d = '0;  p_d = '0;  a_d = '0;  root_d = 1'b1;
    end

    if (cmd_i.ch_read) goto_raddr = {p_q, a_q};

    if (cmd_i.ch_check) begin
      if (hit) begin
        q_we   = 1'b1;
        tail_d = tail_q + SW'(1);
        t_d    = goto_rdata;
        f_d    = fp_q;
        g_d    = '0;
      end else begin
        a_d = a_q + AW'(1);
      end
    end

    if (cmd_i.fg_read) goto_raddr = {f_q, a_q};

    if (cmd_i.fg_check) begin
      fail_raddr = f_q;
      g_d = (goto_rdata == t_q) ? '0 : goto_rdata;
    end

    if (cmd_i.fl_load) f_d = fail_rdata;

    if (cmd_i.own_read) begin
      fail_we  = 1'b1;
      om_raddr = g_q;
    end

    if (cmd_i.own_write) begin
      om_we = 1'b1;
      a_d   = a_q + AW'(1);
    end

    if (cmd_i.np_read) begin
      if (head_q != tail_q) begin
        head_d = head_q + SW'(1);
      end else begin
        built_d = 1'b1;
      end
    end

    if (cmd_i.pw_load) begin
      p_d        = q_rdata;
      fail_raddr = q_rdata;
    end

    if (cmd_i.pf_load) begin
      fp_d   = fail_rdata;
      a_d    = '0;
      root_d = 1'b0;
    end

    if (cmd_i.m_check) begin
      fail_raddr = s_q;
      om_raddr   = goto_rdata;
      if (hit || s_q == '0) begin
        s_d  = goto_rdata;
        ms_d = goto_rdata;
      end
    end

    if (cmd_i.m_fail) s_d = fail_rdata;

    if (cmd_i.m_mask) begin
      rmask_d = om_rdata;
      if (pos_q != '1) begin
        pos_d  = pos_q + POSW'(1);
        rpos_d = pos_q + POSW'(1);
      end else begin
        rpos_d = pos_q;
      end
    end

    if (cmd_i.out_load) begin
      mvalid_d = 1'b1;
      mdata_d  = {3'b000, rpos_q, ones, rmask_q};
      muser_d  = rstat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= '0;
      ins_q    <= '0;
      ms_q     <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      sc_q     <= CW'(1);
      kc_q     <= '0;
      pos_q    <= '0;
      built_q  <= 1'b0;
      drop_q   <= 1'b0;
      root_q   <= 1'b0;
      vld_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      sweep_q  <= sweep_d;
      ins_q    <= ins_d;
      ms_q     <= ms_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      sc_q     <= sc_d;
      kc_q     <= kc_d;
      pos_q    <= pos_d;
      built_q  <= built_d;
      drop_q   <= drop_d;
      root_q   <= root_d;
      vld_q    <= vld_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    p_q     <= p_d;
    t_q     <= t_d;
    f_q     <= f_d;
    fp_q    <= fp_d;
    g_q     <= g_d;
    a_q     <= a_d;
    last_q  <= last_d;
    start_q <= start_d;
    rmask_q <= rmask_d;
    rpos_q  <= rpos_d;
    rstat_q <= rstat_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  assign sts_o.in_func    = in_func;
  assign sts_o.built      = built_q;
  assign sts_o.sweep_last = &sweep_q;
  assign sts_o.goto_hit   = hit;
  assign sts_o.a_last     = &a_q;
  assign sts_o.root_phase = root_q;
  assign sts_o.f_root     = (f_q == '0);
  assign sts_o.s_root     = (s_q == '0);
  assign sts_o.q_more     = (head_q != tail_q) && !start_q | (head_q != tail_q);
  assign sts_o.out_free   = !mvalid_q || m_tready_i;

  assign m_tvalid_o = mvalid_q;
  assign m_tdata_o  = mdata_q;
  assign m_tuser_o  = muser_q;

endmodule

@@ design/multi_keyword_string_matcher.sv @@
// Aho-Corasick keyword matcher with one result per request.
// The slave stream carries requests: tuser selects clear, insert, build or
// match, tdata holds the byte, tlast ends a keyword and tuser bit 2 restarts
// the text. The master stream returns the keyword mask, its bit count, the
// 1-based text position and a status code for every request.
// An insert does one goto read and one update. A match byte reads the goto
// memory and follows a failure link on each miss outside the root before it
// reads the output mask. The result is loaded as the controller returns to
// idle, so it appears when the next request can be taken. A build walks
// every byte value of the root and of each state in breadth-first order and
// sets the failure link of each child it finds. Clear sweeps the 16384-entry
// goto memory one entry a cycle. The goto memory has one registered read
// port, so each lookup is a read step followed by a check step. After reset
// the same sweep of all 16384 entries runs before the first request
// is taken. A result waits in the output register while the receiver stalls,
// and the next request is accepted meanwhile; its result is held back until
// the register is free, and no further request is taken until then.
module multi_keyword_string_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // symbol
  input  logic        s_axis_tlast,  // keyword_end
  input  logic [2:0]  s_axis_tuser,  // func[1:0], text_start[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // match_mask[15:0], match_count[20:16],
                                     // end_position[36:21], zero fill
  output logic [1:0]  m_axis_tuser   // status
);

  mksm_pkg::cmd_t cmd;
  mksm_pkg::sts_t sts;

  mksm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mksm_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata),
    .s_tlast_i (s_axis_tlast),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT = 150000;
  localparam int NSTATE     = 64;
  localparam int NSYM       = 256;
  localparam int NKW        = 16;

  typedef struct {
    logic [15:0]       mask;
    logic [4:0]        cnt;
    logic [15:0]       pos;
    mksm_pkg::status_e st;
  } result_t;

  class match_scoreboard;
    int unsigned goto_tbl[NSTATE*NSYM];
    int unsigned fail_tbl[NSTATE];
    bit [63:0]   set_tbl[NSTATE];
    int unsigned kw_tag[NSTATE];
    int unsigned n_states, n_kw, cur_ins, cur_match, text_pos;
    bit          built, dropping;
    result_t     pending[$];
    int          errors, n_checked, n_hits;

    function void wipe();
      foreach (goto_tbl[i]) goto_tbl[i] = 0;
      foreach (set_tbl[i]) begin
        set_tbl[i] = '0;
        kw_tag[i] = 0;
      end
      n_states = 1;
      n_kw = 0;
      cur_ins = 0;
      cur_match = 0;
      text_pos = 0;
      built = 0;
      dropping = 0;
    endfunction

    function new();
      foreach (fail_tbl[i]) fail_tbl[i] = 0;
      wipe();
      errors = 0;
      n_checked = 0;
      n_hits = 0;
    endfunction

    function bit [63:0] tag_bit(int unsigned s);
      return kw_tag[s] == 0 ? 64'd0 : (64'd1 << (kw_tag[s] - 1));
    endfunction

    function mksm_pkg::status_e add_byte(int unsigned a, bit last);
      int unsigned t;
      mksm_pkg::status_e st;
      st = mksm_pkg::STAT_OK;
      if (dropping) begin
        st = mksm_pkg::STAT_FULL;
      end else begin
        t = goto_tbl[cur_ins*NSYM + a];
        if (t == 0) begin
          if (n_states >= NSTATE) begin
            dropping = 1;
            st = mksm_pkg::STAT_FULL;
          end else begin
            t = n_states++;
            goto_tbl[cur_ins*NSYM + a] = t;
          end
        end
        if (!dropping) begin
          cur_ins = t;
          if (last) begin
            if (n_kw >= NKW) begin
              st = mksm_pkg::STAT_KWORDS;
            end else begin
              kw_tag[cur_ins] = n_kw + 1;
              n_kw++;
            end
          end
        end
      end
      built = 0;
      if (last) begin
        dropping = 0;
        cur_ins = 0;
      end
      return st;
    endfunction

    function void link_states();
      int unsigned order[$];
      int unsigned p, t, f, g, guard;
      foreach (set_tbl[s]) set_tbl[s] = tag_bit(s);
      set_tbl[0] = '0;
      fail_tbl[0] = 0;
      for (int a = 0; a < NSYM; a++) begin
        t = goto_tbl[a];
        if (t != 0) begin
          fail_tbl[t] = 0;
          order.push_back(t);
        end
      end
      while (order.size() > 0) begin
        p = order.pop_front();
        for (int a = 0; a < NSYM; a++) begin
          t = goto_tbl[p*NSYM + a];
          if (t != 0) begin
            order.push_back(t);
            f = fail_tbl[p];
            guard = 0;
            while (goto_tbl[f*NSYM + a] == 0 && f != 0 && guard < NSTATE) begin
              f = fail_tbl[f];
              guard++;
            end
            g = goto_tbl[f*NSYM + a];
            if (g == t) g = 0;
            fail_tbl[t] = g;
            set_tbl[t] = tag_bit(t) | set_tbl[g];
          end
        end
      end
      built = 1;
    endfunction

    function void note_request(mksm_pkg::func_e f, logic [7:0] sym, bit last, bit start);
      result_t r;
      int unsigned s, guard;
      r.mask = '0;
      r.cnt = '0;
      r.pos = '0;
      r.st = mksm_pkg::STAT_OK;
      case (f)
        mksm_pkg::FUNC_CLEAR: wipe();
        mksm_pkg::FUNC_INSERT: r.st = add_byte(32'(sym), last);
        mksm_pkg::FUNC_BUILD: link_states();
        default: begin
          if (!built) begin
            r.st = mksm_pkg::STAT_NBUILT;
          end else begin
            if (start) begin
              cur_match = 0;
              text_pos = 0;
            end
            s = cur_match;
            guard = 0;
            while (goto_tbl[s*NSYM + sym] == 0 && s != 0 && guard < NSTATE) begin
              s = fail_tbl[s];
              guard++;
            end
            s = goto_tbl[s*NSYM + sym];
            cur_match = s;
            if (text_pos < 65535) text_pos++;
            r.pos = 16'(text_pos);
            r.mask = set_tbl[s][15:0];
            r.cnt = 5'($countones(r.mask));
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [39:0] data, logic [1:0] user);
      result_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.mask != 0) n_hits++;
      if (data[15:0] !== e.mask)
        report($sformatf("mask %h, expected %h", data[15:0], e.mask));
      if (data[20:16] !== e.cnt)
        report($sformatf("count %0d, expected %0d", data[20:16], e.cnt));
      if (data[36:21] !== e.pos)
        report($sformatf("position %0d, expected %0d", data[36:21], e.pos));
      if (data[39:37] !== 3'b000)
        report("fill bits not zero");
      if (user !== e.st)
        report($sformatf("status %0d, expected %0d", user, e.st));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  match_scoreboard sb = new();
  int  burst_left = 0;
  int  hold_cycles = 0;
  int  n_sent = 0;
  int  idle_cycles = 0;
  int  rx_left = 0;
  bit  rx_ready = 1;

  multi_keyword_string_matcher uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(mksm_pkg::func_e'(s_axis_tuser[1:0]), s_axis_tdata, s_axis_tlast,
                      s_axis_tuser[2]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_ready = ($urandom_range(0, 3) != 0);
        rx_left = rx_ready ? $urandom_range(1, 30) : $urandom_range(1, 8);
      end
      rx_left--;
      m_axis_tready <= rx_ready;
    end
  end

  task automatic send(mksm_pkg::func_e f, logic [7:0] sym, bit last, bit start);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= sym;
    s_axis_tlast <= last;
    s_axis_tuser <= {start, f};
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    n_sent++;
  endtask

  function automatic logic [7:0] pick_symbol();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100));
  endfunction

  task automatic run_phase(int n_words, int max_len, int n_text);
    int len;
    send(mksm_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
    for (int k = 0; k < n_words; k++) begin
      len = $urandom_range(1, max_len);
      for (int j = 0; j < len; j++)
        send(mksm_pkg::FUNC_INSERT, pick_symbol(), j == len - 1,
             1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 4) == 0)
      send(mksm_pkg::FUNC_MATCH, pick_symbol(), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    send(mksm_pkg::FUNC_BUILD, 8'($urandom), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
    for (int j = 0; j < n_text; j++) begin
      if ($urandom_range(0, 60) == 0)
        send(mksm_pkg::FUNC_INSERT, pick_symbol(), 1, 0);
      else if ($urandom_range(0, 80) == 0)
        send(mksm_pkg::FUNC_BUILD, 8'($urandom), 0, 0);
      send(mksm_pkg::FUNC_MATCH, pick_symbol(), 1'($urandom_range(0, 1)),
           j == 0 || $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    send(mksm_pkg::FUNC_MATCH, 8'h41, 0, 1);
    send(mksm_pkg::FUNC_INSERT, 8'h00, 0, 0);
    send(mksm_pkg::FUNC_INSERT, 8'hFF, 1, 1);
    send(mksm_pkg::FUNC_INSERT, 8'hFF, 1, 0);
    send(mksm_pkg::FUNC_INSERT, 8'hFF, 1, 0);
    send(mksm_pkg::FUNC_INSERT, 8'h00, 1, 0);
    send(mksm_pkg::FUNC_BUILD, 8'h00, 0, 0);
    send(mksm_pkg::FUNC_MATCH, 8'h00, 0, 1);
    send(mksm_pkg::FUNC_MATCH, 8'hFF, 1, 0);
    send(mksm_pkg::FUNC_MATCH, 8'hFF, 0, 0);
    send(mksm_pkg::FUNC_MATCH, 8'h07, 0, 0);
    send(mksm_pkg::FUNC_INSERT, 8'h41, 1, 0);
    send(mksm_pkg::FUNC_MATCH, 8'h41, 0, 1);
    send(mksm_pkg::FUNC_BUILD, 8'hFF, 1, 1);
    send(mksm_pkg::FUNC_MATCH, 8'h41, 0, 1);
    send(mksm_pkg::FUNC_MATCH, 8'h41, 0, 1);
    send(mksm_pkg::FUNC_CLEAR, 8'h00, 0, 0);
    send(mksm_pkg::FUNC_MATCH, 8'h00, 0, 1);

    // One keyword longer than the state store: the tail is dropped.
    send(mksm_pkg::FUNC_CLEAR, 8'h00, 0, 0);
    for (int j = 0; j < 66; j++) send(mksm_pkg::FUNC_INSERT, 8'(j), j == 65, 0);
    send(mksm_pkg::FUNC_INSERT, 8'h00, 1, 0);
    send(mksm_pkg::FUNC_BUILD, 8'h00, 0, 0);
    for (int j = 0; j < 8; j++) send(mksm_pkg::FUNC_MATCH, 8'(j), 0, j == 0);

    run_phase(20, 4, 90);
    hold_cycles = 400;
    run_phase(8, 3, 120);
    while (n_sent < 980) run_phase($urandom_range(3, 12), $urandom_range(2, 6), 110);
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Run covered %0d requests and %0d results, %0d of them keyword hits,",
             n_sent, sb.n_checked, sb.n_hits);
    $display("including store overflow, the keyword limit, rebuilds and early matches.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
